### hdl/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg
// Shared types, token kind codes, character classes and keyword tables for
// the keyword lexer stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kls_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int MAX_TOKENS        = 4;
  localparam int NUM_KEYWORDS      = 6;

  // token kinds
  localparam logic [4:0] KIND_STRING  = 5'd8;
  localparam logic [4:0] KIND_NUMBER  = 5'd9;
  localparam logic [4:0] KIND_IDENT   = 5'd10;
  localparam logic [4:0] KIND_KW0     = 5'd11;
  localparam logic [4:0] KIND_EOF     = 5'd17;
  localparam logic [4:0] KIND_UNKNOWN = 5'd18;
  localparam logic [4:0] KIND_UNFIN   = 5'd19;

  // characters with a role of their own
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] line;
  } token_t;

  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic [2:0]              cnt;
  } scan_res_t;

  function automatic token_t mk_tok(input logic [4:0] kind, input logic [31:0] start,
                                    input logic [31:0] len, input logic [31:0] line);
    token_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line;
    return t;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
  endfunction

  // {hit, operator index}
  function automatic logic [3:0] op_code(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      8'h28:   r = 4'b1_000;
      8'h29:   r = 4'b1_001;
      8'h2B:   r = 4'b1_010;
      8'h2D:   r = 4'b1_011;
      8'h2A:   r = 4'b1_100;
      8'h2F:   r = 4'b1_101;
      8'h3D:   r = 4'b1_110;
      8'h3A:   r = 4'b1_111;
      default: r = 4'b0_000;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] i);
    logic [2:0] r;
    case (i)
      3'd0:    r = 3'd5;
      3'd1:    r = 3'd6;
      3'd2:    r = 3'd5;
      3'd3:    r = 3'd4;
      3'd4:    r = 3'd5;
      3'd5:    r = 3'd6;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // character k of keyword i, k below 6
  function automatic logic [7:0] kw_char(input logic [2:0] i, input logic [2:0] k);
    logic [47:0] w;
    case (i)
      3'd0:    w = {"rakho", 8'h00};
      3'd1:    w = "farmao";
      3'd2:    w = {"pocho", 8'h00};
      3'd3:    w = {"agar", 16'h0000};
      3'd4:    w = {"warna", 8'h00};
      3'd5:    w = "jabtak";
      default: w = '0;
    endcase
    return w[{3'd5 - k, 3'b000} +: 8];
  endfunction

endpackage

### hdl/kls_scan.sv
// ----------------------------------------------------------------------------
// kls_scan
// Scanner state and the per-byte token logic: on each advance, one item is
// scanned against the current mode and up to four tokens are produced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kls_scan #(
  parameter int POSITION_BITS = kls_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [7:0]          char_code,
  input  logic                char_valid,
  input  logic                end_of_input,
  output kls_pkg::scan_res_t  res
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC,
    MODE_IDENT,
    MODE_STR
  } mode_t;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] lb_r, lb_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [31:0]              line_r, line_nxt;
  logic [5:0]               kc_r, kc_nxt;

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [POSITION_BITS-1:0] dec_sat(input logic [POSITION_BITS-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic logic [POSITION_BITS-1:0] span(input logic [POSITION_BITS-1:0] from,
                                                    input logic [POSITION_BITS-1:0] upto);
    return (upto >= from) ? upto - from : '0;
  endfunction

  function automatic logic [31:0] line_inc(input logic [31:0] v);
    return (v == kls_pkg::LINE_MAX) ? v : v + 32'd1;
  endfunction

  function automatic logic [5:0] narrow(input logic [5:0] cands,
                                        input logic [POSITION_BITS-1:0] k,
                                        input logic [7:0] c);
    logic [7:0] lc;
    logic [5:0] r;
    logic       k_ok;
    lc   = kls_pkg::to_lower(c);
    r    = '0;
    k_ok = (k < {{(POSITION_BITS-3){1'b0}}, 3'd6});
    for (int i = 0; i < kls_pkg::NUM_KEYWORDS; i++) begin
      if (cands[i] && k_ok && (k[2:0] < kls_pkg::kw_len(3'(i))) &&
          (kls_pkg::kw_char(3'(i), k[2:0]) == lc)) begin
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] ident_kind(input logic [5:0] cands,
                                            input logic [POSITION_BITS-1:0] len);
    logic [4:0] kind;
    logic       found;
    kind  = kls_pkg::KIND_IDENT;
    found = 1'b0;
    for (int i = 0; i < kls_pkg::NUM_KEYWORDS; i++) begin
      if (!found && cands[i] &&
          (len == {{(POSITION_BITS-3){1'b0}}, kls_pkg::kw_len(3'(i))})) begin
        kind  = kls_pkg::KIND_KW0 + 5'(i);
        found = 1'b1;
      end
    end
    return kind;
  endfunction

  always_comb begin
    mode_t                    mode;
    logic [POSITION_BITS-1:0] lb;
    logic [POSITION_BITS-1:0] pos;
    logic [POSITION_BITS-1:0] len;
    logic [31:0]              line;
    logic [5:0]               kc;
    logic [2:0]               n;
    logic [3:0]               op;
    logic                     go_idle;
    kls_pkg::scan_res_t       r;

    mode    = mode_r;
    lb      = lb_r;
    pos     = pos_r;
    line    = line_r;
    kc      = kc_r;
    n       = 3'd0;
    go_idle = 1'b0;
    r       = '0;
    op      = kls_pkg::op_code(char_code);
    len     = span(lb, pos);

    if (char_valid) begin
      case (mode)
        MODE_INT, MODE_FRAC: begin
          if (!kls_pkg::is_digit(char_code)) begin
            if ((mode == MODE_INT) && (char_code == kls_pkg::CH_DOT)) begin
              mode = MODE_DOT;
            end else begin
              r.tok[n[1:0]] = kls_pkg::mk_tok(kls_pkg::KIND_NUMBER, 32'(lb), 32'(len), line);
              n = n + 3'd1;
              go_idle = 1'b1;
            end
          end
        end
        MODE_DOT: begin
          if (kls_pkg::is_digit(char_code)) begin
            mode = MODE_FRAC;
          end else begin
            r.tok[n[1:0]] = kls_pkg::mk_tok(kls_pkg::KIND_NUMBER, 32'(lb),
                                            32'(dec_sat(len)), line);
            n = n + 3'd1;
            r.tok[n[1:0]] = kls_pkg::mk_tok(kls_pkg::KIND_UNKNOWN, 32'(dec_sat(pos)),
                                            32'd1, line);
            n = n + 3'd1;
            go_idle = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (kls_pkg::is_word(char_code)) begin
            kc = narrow(kc, len, char_code);
          end else begin
            r.tok[n[1:0]] = kls_pkg::mk_tok(ident_kind(kc, len), 32'(lb), 32'(len), line);
            n = n + 3'd1;
            go_idle = 1'b1;
          end
        end
        MODE_STR: begin
          if (char_code == kls_pkg::CH_QUOTE) begin
            r.tok[n[1:0]] = kls_pkg::mk_tok(kls_pkg::KIND_STRING, 32'(lb), 32'(len), line);
            n = n + 3'd1;
            mode = MODE_IDLE;
          end else if (char_code == kls_pkg::CH_LF) begin
            line = line_inc(line);
          end
        end
        default: begin
          go_idle = 1'b1;
        end
      endcase

      if (go_idle) begin
        mode = MODE_IDLE;
        if (op[3]) begin
          r.tok[n[1:0]] = kls_pkg::mk_tok({2'b00, op[2:0]}, 32'(pos), 32'd1, line);
          n = n + 3'd1;
        end else if (char_code == kls_pkg::CH_QUOTE) begin
          lb   = sat_inc(pos);
          mode = MODE_STR;
        end else if ((char_code == kls_pkg::CH_SPACE) || (char_code == kls_pkg::CH_CR) ||
                     (char_code == kls_pkg::CH_TAB)) begin
          mode = MODE_IDLE;
        end else if (char_code == kls_pkg::CH_LF) begin
          line = line_inc(line);
        end else if (kls_pkg::is_digit(char_code)) begin
          lb   = pos;
          mode = MODE_INT;
        end else if (kls_pkg::is_alpha(char_code) || (char_code == kls_pkg::CH_UNDER)) begin
          lb   = pos;
          kc   = narrow(6'h3F, '0, char_code);
          mode = MODE_IDENT;
        end else begin
          r.tok[n[1:0]] = kls_pkg::mk_tok(kls_pkg::KIND_UNKNOWN, 32'(pos), 32'd1, line);
          n = n + 3'd1;
        end
      end

      pos = sat_inc(pos);
    end

    if (end_of_input) begin
      len = span(lb, pos);
      case (mode)
        MODE_INT, MODE_FRAC: begin
          r.tok[n[1:0]] = kls_pkg::mk_tok(kls_pkg::KIND_NUMBER, 32'(lb), 32'(len), line);
          n = n + 3'd1;
        end
        MODE_DOT: begin
          r.tok[n[1:0]] = kls_pkg::mk_tok(kls_pkg::KIND_NUMBER, 32'(lb),
                                          32'(dec_sat(len)), line);
          n = n + 3'd1;
          r.tok[n[1:0]] = kls_pkg::mk_tok(kls_pkg::KIND_UNKNOWN, 32'(dec_sat(pos)),
                                          32'd1, line);
          n = n + 3'd1;
        end
        MODE_IDENT: begin
          r.tok[n[1:0]] = kls_pkg::mk_tok(ident_kind(kc, len), 32'(lb), 32'(len), line);
          n = n + 3'd1;
        end
        MODE_STR: begin
          r.tok[n[1:0]] = kls_pkg::mk_tok(kls_pkg::KIND_UNFIN, 32'(lb), 32'(len), line);
          n = n + 3'd1;
        end
        default: begin
          n = n;
        end
      endcase
      r.tok[n[1:0]] = kls_pkg::mk_tok(kls_pkg::KIND_EOF, 32'(pos), 32'd0, line);
      n = n + 3'd1;
      // new source starts after the end-of-file token
      mode = MODE_IDLE;
      lb   = '0;
      pos  = '0;
      line = 32'd1;
      kc   = 6'h3F;
    end

    r.cnt    = n;
    res      = r;
    mode_nxt = mode;
    lb_nxt   = lb;
    pos_nxt  = pos;
    line_nxt = line;
    kc_nxt   = kc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      lb_r   <= '0;
      pos_r  <= '0;
      line_r <= 32'd1;
      kc_r   <= 6'h3F;
    end else if (advance) begin
      mode_r <= mode_nxt;
      lb_r   <= lb_nxt;
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
      kc_r   <= kc_nxt;
    end
  end

endmodule

### hdl/keyword_lexer_stream_top.sv
// ----------------------------------------------------------------------------
// keyword_lexer_stream_top
// Streaming tokenizer: one source byte per request in, one token per request
// out. An item is taken into an input register, scanned combinationally and
// its tokens land in a four-entry result buffer that drains one token per
// cycle while out_ready is high. The input side takes one item per cycle as
// long as each item gives at most one token and out_ready is high; an item
// that gives more holds the result buffer until its last token is taken. The
// input register lets one more item wait while the buffer still holds
// tokens. Start, length and line counters saturate; after the end-of-file
// token the scanner returns to its reset state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyword_lexer_stream_top #(
  parameter int POSITION_BITS = kls_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_char_valid,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [31:0] out_lexeme_start,
  output logic [31:0] out_lexeme_length,
  output logic [31:0] out_line_number,
  output logic        out_last_of_run
);

  logic                                     ir_valid_r;
  logic [7:0]                               ir_code_r;
  logic                                     ir_cv_r;
  logic                                     ir_eoi_r;
  kls_pkg::token_t [kls_pkg::MAX_TOKENS-1:0] tok_r;
  logic [2:0]                               left_r;
  logic [1:0]                               idx_r;
  logic                                     buf_free;
  logic                                     advance;
  kls_pkg::scan_res_t                       scan_res;
  kls_pkg::token_t                          head;

  kls_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .char_code    (ir_code_r),
    .char_valid   (ir_cv_r),
    .end_of_input (ir_eoi_r),
    .res          (scan_res)
  );

  assign buf_free = (left_r == 3'd0) || ((left_r == 3'd1) && out_ready);
  assign advance  = ir_valid_r && buf_free;
  assign in_ready = !ir_valid_r || buf_free;

  assign head              = tok_r[idx_r];
  assign out_valid         = (left_r != 3'd0);
  assign out_token_kind    = head.kind;
  assign out_lexeme_start  = head.start;
  assign out_lexeme_length = head.len;
  assign out_line_number   = head.line;
  assign out_last_of_run   = (left_r == 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
      left_r     <= 3'd0;
      idx_r      <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        ir_valid_r <= 1'b1;
      end else if (advance) begin
        ir_valid_r <= 1'b0;
      end
      if (advance) begin
        left_r <= scan_res.cnt;
        idx_r  <= 2'd0;
      end else if (out_valid && out_ready) begin
        left_r <= left_r - 3'd1;
        idx_r  <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_code_r <= in_char_code;
      ir_cv_r   <= in_char_valid;
      ir_eoi_r  <= in_end_of_input;
    end
    if (advance) begin
      tok_r <= scan_res.tok;
    end
  end

  // scanned tokens show up on the output the next cycle
  a_tokens_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (scan_res.cnt != 3'd0)) |=> out_valid)
    else $error("scanned tokens not presented");

  // a new scan never overwrites a token that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> ((left_r == 3'd0) || ((left_r == 3'd1) && out_ready)))
    else $error("result buffer overwritten");

  // end-of-file is always the final token of its item
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == kls_pkg::KIND_EOF)) |-> out_last_of_run)
    else $error("eof token not last of run");

  // input register only refills once its item has moved on
  a_ir_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ir_valid_r && !advance) |=> (ir_valid_r && $stable(ir_code_r) && $stable(ir_eoi_r)))
    else $error("pending input item lost");

endmodule
